// ===== hdl/scpa_pkg.sv =====
// Shared types, constants and helpers of the size-class pool allocator.
// No dependencies; scpa_counters, the top level and the bench import this package.
package scpa_pkg;

  // Geometry
  localparam int CLASSES = 8;
  localparam int SLOTS   = 16;
  localparam int REGS    = 8;
  localparam int CLS_W   = 3;
  localparam int SLOT_W  = 4;
  localparam int CNT_W   = 5;
  localparam int CFG_W   = 5;
  localparam int SIZE_W  = 16;
  localparam int ADDR_W  = CLS_W + SLOT_W;
  localparam int DEPTH   = CLASSES * SLOTS;

  localparam logic [CFG_W-1:0] ENTRIES_RST = CFG_W'(SLOTS);
  localparam logic [CNT_W-1:0] CNT_FULL    = CNT_W'(SLOTS);

  // Commands
  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_REALLOC = 2'd2,
    CMD_INIT    = 2'd3
  } cmd_e;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef logic [CLASSES-1:0][CNT_W-1:0] cnt_arr_t;
  typedef logic [REGS-1:0][CFG_W-1:0]    cfg_arr_t;

  // Counter update request from the sequencer
  typedef struct packed {
    logic             commit;
    logic             init;
    logic             pop;
    logic [CLS_W-1:0] pop_cls;
    logic             push;
    logic [CLS_W-1:0] push_cls;
  } upd_t;

  // Class chosen for an allocation
  typedef struct packed {
    logic             found;
    logic [CLS_W-1:0] cls;
  } sel_t;

  // True when a block of class k holds size bytes
  function automatic logic fits(logic [SIZE_W-1:0] size, logic [CLS_W-1:0] k);
    return {1'b0, size} <= ((SIZE_W+1)'(1) << k);
  endfunction

  // True when a class index lies beyond the configured classes
  function automatic logic cls_bad(logic [CLS_W-1:0] k);
    return {1'b0, k} >= (CLS_W+1)'(CLASSES);
  endfunction

endpackage

// ===== hdl/scpa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module scpa_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/scpa_counters.sv =====
// Per-class free/used counters, class selection for allocation and counter update.
// Depends on scpa_pkg.
module scpa_counters
  import scpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SIZE_W-1:0] req_size_i,
  input  cfg_arr_t          entries_i,
  input  upd_t              upd_i,
  output sel_t              sel_o,
  output cnt_arr_t          free_o,
  output cnt_arr_t          free_nxt_o,
  output cnt_arr_t          used_nxt_o,
  output logic              push_full_o,
  output logic [SLOT_W-1:0] push_idx_o
);

  cnt_arr_t free_q, free_d;
  cnt_arr_t used_q, used_d;
  cnt_arr_t free_mid, used_mid;

  // Pick the smallest fitting class that still has a free block
  always_comb begin
    sel_o = '0;
    for (int k = CLASSES - 1; k >= 0; k--) begin
      if (fits(req_size_i, CLS_W'(k)) && (free_q[k] != '0)) begin
        sel_o.found = 1'b1;
        sel_o.cls   = CLS_W'(k);
      end
    end
  end

  // Apply pop first, then push on the counts left by the pop
  always_comb begin
    free_mid = free_q;
    used_mid = used_q;
    if (upd_i.pop) begin
      free_mid[upd_i.pop_cls] = free_q[upd_i.pop_cls] - CNT_W'(1);
      if (used_q[upd_i.pop_cls] < CNT_FULL) begin
        used_mid[upd_i.pop_cls] = used_q[upd_i.pop_cls] + CNT_W'(1);
      end
    end
    push_full_o = free_mid[upd_i.push_cls] >= CNT_FULL;
    push_idx_o  = free_mid[upd_i.push_cls][SLOT_W-1:0];
    free_d = free_mid;
    used_d = used_mid;
    if (upd_i.push && !push_full_o) begin
      free_d[upd_i.push_cls] = free_mid[upd_i.push_cls] + CNT_W'(1);
      if (used_mid[upd_i.push_cls] != '0) begin
        used_d[upd_i.push_cls] = used_mid[upd_i.push_cls] - CNT_W'(1);
      end
    end
    // Rebuild every class from the entry registers, saturated to the pool size
    if (upd_i.init) begin
      for (int i = 0; i < CLASSES; i++) begin
        free_d[i] = '0;
        if (i < REGS) begin
          free_d[i] = (entries_i[i] > ENTRIES_RST) ? CNT_FULL : CNT_W'(entries_i[i]);
        end
        used_d[i] = '0;
      end
    end
  end

  // Hold counters until the sequencer commits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CLASSES; i++) begin
        free_q[i] <= CNT_FULL;
        used_q[i] <= '0;
      end
    end else if (upd_i.commit) begin
      free_q <= free_d;
      used_q <= used_d;
    end
  end

  assign free_o     = free_q;
  assign free_nxt_o = free_d;
  assign used_nxt_o = used_d;

  // A pop only ever targets a class that has a free block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i.commit && upd_i.pop && !upd_i.init |-> free_q[upd_i.pop_cls] != '0)
    else $error("pop from empty class");

  // Free counter of the pushed class never passes the pool size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i.commit && upd_i.push && !upd_i.init |=> free_q[$past(upd_i.push_cls)] <= CNT_FULL)
    else $error("free count overflow");

endmodule

// ===== hdl/size_class_pool_allocator_top.sv =====
// Size-class pool allocator: top level with request sequencer and free-stack memory.
// Depends on scpa_pkg, scpa_ram and scpa_counters.
//
// Usage:
//   Requests (cmd_i, req_size_i, has_block_i, block_class_i, block_slot_i)
//   transfer on in_valid_i & in_ready_o; results (status_o, out_class_o,
//   out_slot_o, moved_o, free_left_o, used_now_o) transfer on
//   out_valid_o & out_ready_i. Every request gives exactly one result.
//   On transfer a request reads the top slot of its chosen class from the
//   free-stack memory; the execute state then writes back any freed slot,
//   updates the counters and registers the result; no new request is taken
//   meanwhile. A request is taken while the previous result still waits in
//   the output register; if that result is not taken, the request holds in
//   the execute state until the output register frees up. The user must
//   write the class entry registers through cfg_we_i/cfg_idx_i/cfg_wdata_i
//   only while no request is in flight; the block does not enforce it. They
//   act on the next init. Reset restores the full pools (16 blocks per
//   class, slot 15 on top) at once: per-entry valid bits make never-written
//   stack entries read as their own index, so no clearing pass is needed.
module size_class_pool_allocator_top
  import scpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        cmd_i,
  input  logic [SIZE_W-1:0] req_size_i,
  input  logic              has_block_i,
  input  logic [CLS_W-1:0]  block_class_i,
  input  logic [SLOT_W-1:0] block_slot_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [CLS_W-1:0]  out_class_o,
  output logic [SLOT_W-1:0] out_slot_o,
  output logic              moved_o,
  output logic [CNT_W-1:0]  free_left_o,
  output logic [CNT_W-1:0]  used_now_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  cfg_arr_t entries_q;

  // Captured request
  cmd_e              cmd_q;
  logic              has_q;
  logic [CLS_W-1:0]  bcls_q;
  logic [SLOT_W-1:0] bslot_q;
  logic              keep_q;
  sel_t              sel_q;
  logic [ADDR_W-1:0] raddr_q;

  // Output register
  logic              out_valid_q;
  logic [1:0]        status_q;
  logic [CLS_W-1:0]  class_q;
  logic [SLOT_W-1:0] slot_q;
  logic              moved_q;
  logic [CNT_W-1:0]  free_left_q;
  logic [CNT_W-1:0]  used_now_q;

  logic [DEPTH-1:0]  valid_q;

  logic              accept;
  logic              exec_done;
  sel_t              sel;
  upd_t              upd;
  cnt_arr_t          free_cur, free_nxt, used_nxt;
  logic              push_full;
  logic [SLOT_W-1:0] push_idx;
  logic [ADDR_W-1:0] raddr;
  logic [SLOT_W-1:0] rdata;
  logic [SLOT_W-1:0] rd_slot;
  logic              ram_we;
  logic [ADDR_W-1:0] waddr;
  logic              has_eff;

  logic [1:0]        res_status;
  logic [CLS_W-1:0]  res_class;
  logic [SLOT_W-1:0] res_slot;
  logic              res_moved;
  logic [CNT_W-1:0]  res_free;
  logic [CNT_W-1:0]  res_used;

  assign accept    = in_valid_i && in_ready_o;
  assign exec_done = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (state_q == ST_IDLE);

  // Counters and class selection
  scpa_counters u_counters (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_size_i  (req_size_i),
    .entries_i   (entries_q),
    .upd_i       (upd),
    .sel_o       (sel),
    .free_o      (free_cur),
    .free_nxt_o  (free_nxt),
    .used_nxt_o  (used_nxt),
    .push_full_o (push_full),
    .push_idx_o  (push_idx)
  );

  // Read the top of the chosen class on transfer
  assign raddr = {sel.cls, SLOT_W'(free_cur[sel.cls] - CNT_W'(1))};

  scpa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (bslot_q),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Never-written entries hold their own slot number
  assign rd_slot = valid_q[raddr_q] ? rdata : raddr_q[SLOT_W-1:0];
  assign has_eff = has_q && !cls_bad(bcls_q);
  assign waddr   = {bcls_q, push_idx};
  assign ram_we  = exec_done && upd.push && !push_full;

  // Decode the captured command into counter updates and a result
  always_comb begin
    upd         = '0;
    upd.commit  = exec_done;
    upd.pop_cls = sel_q.cls;
    upd.push_cls = bcls_q;
    res_status  = ST_OK;
    res_class   = '0;
    res_slot    = '0;
    res_moved   = 1'b0;
    res_free    = '0;
    res_used    = '0;
    case (cmd_q)
      CMD_INIT: begin
        upd.init = 1'b1;
        res_free = free_nxt[0];
        res_used = used_nxt[0];
      end
      CMD_ALLOC: begin
        if (sel_q.found) begin
          upd.pop   = 1'b1;
          res_class = sel_q.cls;
          res_slot  = rd_slot;
          res_free  = free_nxt[sel_q.cls];
          res_used  = used_nxt[sel_q.cls];
        end else begin
          res_status = ST_NOFIT;
        end
      end
      CMD_FREE: begin
        if (!cls_bad(bcls_q)) begin
          upd.push   = 1'b1;
          res_status = push_full ? ST_FULL : ST_OK;
          res_class  = bcls_q;
          res_slot   = bslot_q;
          res_free   = free_nxt[bcls_q];
          res_used   = used_nxt[bcls_q];
        end
      end
      CMD_REALLOC: begin
        if (has_eff && keep_q) begin
          res_class = bcls_q;
          res_slot  = bslot_q;
          res_free  = free_nxt[bcls_q];
          res_used  = used_nxt[bcls_q];
        end else if (!sel_q.found) begin
          res_status = ST_NOFIT;
        end else begin
          upd.pop    = 1'b1;
          upd.push   = has_eff;
          res_status = (has_eff && push_full) ? ST_FULL : ST_OK;
          res_moved  = has_eff && !push_full;
          res_class  = sel_q.cls;
          res_slot   = rd_slot;
          res_free   = free_nxt[sel_q.cls];
          res_used   = used_nxt[sel_q.cls];
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // Sequencer: idle, then an execute state that may hold on output stall
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_EXEC;
      ST_EXEC: if (exec_done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the request on transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_e'(cmd_i);
      has_q   <= has_block_i;
      bcls_q  <= block_class_i;
      bslot_q <= block_slot_i;
      keep_q  <= fits(req_size_i, block_class_i);
      sel_q   <= sel;
      raddr_q <= raddr;
    end
  end

  // Entry registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REGS; i++) begin
        entries_q[i] <= ENTRIES_RST;
      end
    end else if (cfg_we_i && ({1'b0, cfg_idx_i} < 4'(REGS))) begin
      entries_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // Valid bits: clear on init, set on every stack write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (exec_done && upd.init) begin
      valid_q <= '0;
    end else if (ram_we) begin
      valid_q[waddr] <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_done) begin
      status_q    <= res_status;
      class_q     <= res_class;
      slot_q      <= res_slot;
      moved_q     <= res_moved;
      free_left_q <= res_free;
      used_now_q  <= res_used;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_class_o = class_q;
  assign out_slot_o  = slot_q;
  assign moved_o     = moved_q;
  assign free_left_o = free_left_q;
  assign used_now_o  = used_now_q;

  // A transfer always starts an execute cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_EXEC)
    else $error("transfer did not start execution");

  // A finished request always presents a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_done |=> out_valid_o)
    else $error("result lost");

  // Stack writes happen only in the execute cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == ST_EXEC)
    else $error("stack write outside execution");

  // A failed allocation reports all-zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_NOFIT |->
      out_class_o == '0 && out_slot_o == '0 && !moved_o &&
      free_left_o == '0 && used_now_o == '0)
    else $error("nonzero fields on failed allocation");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for size_class_pool_allocator_top: directed rows, then random phases.
// Depends on scpa_pkg and the allocator RTL; results are checked against an in-bench model.
`timescale 1ns / 100ps

module tb;
  import scpa_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 250;
  localparam int PHASES      = 7;
  localparam int PRINT_MAX   = 40;

  typedef struct packed {
    cmd_e              cmd;
    logic [SIZE_W-1:0] size;
    logic              has;
    logic [CLS_W-1:0]  cls;
    logic [SLOT_W-1:0] slot;
  } alloc_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [CLS_W-1:0]  cls;
    logic [SLOT_W-1:0] slot;
    logic              moved;
    logic [CNT_W-1:0]  free_left;
    logic [CNT_W-1:0]  used_now;
  } alloc_rsp_t;

  typedef struct packed {
    alloc_req_t req;
    logic       typed;
    alloc_rsp_t want;
  } dir_row_t;

  typedef struct packed {
    logic [CLS_W-1:0]  cls;
    logic [SLOT_W-1:0] slot;
  } blk_t;

  // DUT-facing signals; the driven ones are known from time zero
  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  cmd_e              cmd         = CMD_ALLOC;
  logic [SIZE_W-1:0] req_size    = '0;
  logic              has_block   = 1'b0;
  logic [CLS_W-1:0]  block_class = '0;
  logic [SLOT_W-1:0] block_slot  = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic [1:0]        status;
  logic [CLS_W-1:0]  out_class;
  logic [SLOT_W-1:0] out_slot;
  logic              moved;
  logic [CNT_W-1:0]  free_left;
  logic [CNT_W-1:0]  used_now;
  logic              cfg_we      = 1'b0;
  logic [2:0]        cfg_idx     = '0;
  logic [CFG_W-1:0]  cfg_wdata   = '0;

  // Model state of the pools
  logic [SLOT_W-1:0] stk_mem [CLASSES][SLOTS];
  logic [CNT_W-1:0]  free_cnt [CLASSES];
  logic [CNT_W-1:0]  used_cnt [CLASSES];
  logic [CFG_W-1:0]  entries_cfg [REGS];

  alloc_rsp_t pending_grants [$];
  blk_t       held_blocks [$];
  dir_row_t   dir_rows [$];
  int         err_cnt   = 0;
  int         cycle_cnt = 0;
  int         snd_mode  = 0;
  int         rcv_mode  = 0;

  size_class_pool_allocator_top i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .cmd_i         (cmd),
    .req_size_i    (req_size),
    .has_block_i   (has_block),
    .block_class_i (block_class),
    .block_slot_i  (block_slot),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .out_class_o   (out_class),
    .out_slot_o    (out_slot),
    .moved_o       (moved),
    .free_left_o   (free_left),
    .used_now_o    (used_now),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: end the run if it hangs
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void report_mismatch(string msg);
    err_cnt++;
    if (err_cnt <= PRINT_MAX) $display("%0t mismatch: %s", $realtime, msg);
  endfunction

  function automatic logic size_fits(logic [SIZE_W-1:0] size, int k);
    return (32'd1 << k) >= 32'(size);
  endfunction

  // Refill one class with slots 0..n-1, n clipped to the pool depth
  function automatic void rebuild_class(int k, logic [CFG_W-1:0] n);
    int cnt;
    cnt = (n > SLOTS) ? SLOTS : int'(n);
    for (int i = 0; i < SLOTS; i++) stk_mem[k][i] = (i < cnt) ? SLOT_W'(i) : '0;
    free_cnt[k] = CNT_W'(cnt);
    used_cnt[k] = '0;
  endfunction

  // Pop the top slot of the smallest fitting class that is not empty
  function automatic logic pop_block(logic [SIZE_W-1:0] size, output logic [CLS_W-1:0] k,
                                     output logic [SLOT_W-1:0] s);
    for (int c = 0; c < CLASSES; c++) begin
      if (size_fits(size, c) && free_cnt[c] != 0) begin
        free_cnt[c] = free_cnt[c] - 1'b1;
        s = stk_mem[c][free_cnt[c]];
        if (used_cnt[c] < SLOTS) used_cnt[c] = used_cnt[c] + 1'b1;
        k = CLS_W'(c);
        return 1'b1;
      end
    end
    k = '0;
    s = '0;
    return 1'b0;
  endfunction

  // Push a slot back; a full class drops it
  function automatic logic push_block(logic [CLS_W-1:0] k, logic [SLOT_W-1:0] s);
    if (free_cnt[k] >= SLOTS) return 1'b0;
    stk_mem[k][free_cnt[k]] = s;
    free_cnt[k] = free_cnt[k] + 1'b1;
    if (used_cnt[k] != 0) used_cnt[k] = used_cnt[k] - 1'b1;
    return 1'b1;
  endfunction

  // One request through the pool model: update state, return the grant
  function automatic alloc_rsp_t allocator_step(alloc_req_t r);
    alloc_rsp_t rsp;
    logic [CLS_W-1:0]  k;
    logic [SLOT_W-1:0] s;
    rsp = '0;
    case (r.cmd)
      CMD_INIT: begin
        for (int i = 0; i < CLASSES; i++) rebuild_class(i, entries_cfg[i]);
        rsp.free_left = free_cnt[0];
        rsp.used_now  = used_cnt[0];
      end
      CMD_ALLOC: begin
        if (pop_block(r.size, k, s)) begin
          rsp.cls       = k;
          rsp.slot      = s;
          rsp.free_left = free_cnt[k];
          rsp.used_now  = used_cnt[k];
        end else begin
          rsp.status = ST_NOFIT;
        end
      end
      CMD_FREE: begin
        rsp.status    = push_block(r.cls, r.slot) ? ST_OK : ST_FULL;
        rsp.cls       = r.cls;
        rsp.slot      = r.slot;
        rsp.free_left = free_cnt[r.cls];
        rsp.used_now  = used_cnt[r.cls];
      end
      default: begin
        if (r.has && size_fits(r.size, int'(r.cls))) begin
          // old block is big enough: keep it
          rsp.cls       = r.cls;
          rsp.slot      = r.slot;
          rsp.free_left = free_cnt[r.cls];
          rsp.used_now  = used_cnt[r.cls];
        end else if (pop_block(r.size, k, s)) begin
          if (r.has) begin
            if (push_block(r.cls, r.slot)) rsp.moved = 1'b1;
            else rsp.status = ST_FULL;
          end
          rsp.cls       = k;
          rsp.slot      = s;
          rsp.free_left = free_cnt[k];
          rsp.used_now  = used_cnt[k];
        end else begin
          rsp.status = ST_NOFIT;
        end
      end
    endcase
    return rsp;
  endfunction

  function automatic int draw_gap(int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 16);
      default: return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] draw_size();
    int k;
    k = $urandom_range(0, 7);
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2: return SIZE_W'(1 << k);
      3: return SIZE_W'((1 << k) + 1);
      4: return SIZE_W'($urandom);
      default: return SIZE_W'($urandom_range(1, 128));
    endcase
  endfunction

  function automatic dir_row_t row(cmd_e c, int sz, int hb, int bc, int bs, bit typed,
                                   int st, int oc, int os, int mv, int fl, int un);
    dir_row_t d;
    d.req   = '{cmd: c, size: SIZE_W'(sz), has: 1'(hb), cls: CLS_W'(bc), slot: SLOT_W'(bs)};
    d.typed = typed;
    d.want  = '{status: 2'(st), cls: CLS_W'(oc), slot: SLOT_W'(os), moved: 1'(mv),
                free_left: CNT_W'(fl), used_now: CNT_W'(un)};
    return d;
  endfunction

  // Offer one request, wait for its transfer, then log the grant it should get
  task automatic send_req(alloc_req_t r, logic typed, alloc_rsp_t want, logic from_held);
    alloc_rsp_t got;
    int gap;
    gap = draw_gap(snd_mode);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= r.cmd;
    req_size    <= r.size;
    has_block   <= r.has;
    block_class <= r.cls;
    block_slot  <= r.slot;
    do @(posedge clk); while (!in_ready);
    got = allocator_step(r);
    // track blocks the random traffic may free or move later
    case (r.cmd)
      CMD_ALLOC: if (got.status == ST_OK) held_blocks.push_back('{got.cls, got.slot});
      CMD_REALLOC: begin
        if ((r.has && size_fits(r.size, int'(r.cls))) || got.status == ST_NOFIT) begin
          if (from_held) held_blocks.push_back('{r.cls, r.slot});
        end else begin
          held_blocks.push_back('{got.cls, got.slot});
        end
      end
      CMD_INIT: held_blocks.delete();
      default: ;
    endcase
    pending_grants.push_back(typed ? want : got);
  endtask

  // Drop valid and wait until every grant has come back
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_entries(cfg_arr_t v);
    for (int i = 0; i < REGS; i++) begin
      cfg_we         <= 1'b1;
      cfg_idx        <= 3'(i);
      cfg_wdata      <= v[i];
      entries_cfg[i]  = v[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Random traffic: mostly alloc/free/realloc of live blocks, some noise
  task automatic run_phase(int n_items);
    alloc_req_t r;
    blk_t b;
    logic from_held;
    int idx;
    int pick;
    for (int i = 0; i < n_items; i++) begin
      if (i % 64 == 0) snd_mode = $urandom_range(0, 2);
      r.size    = SIZE_W'($urandom);
      r.has     = 1'($urandom);
      r.cls     = CLS_W'($urandom);
      r.slot    = SLOT_W'($urandom);
      from_held = 1'b0;
      pick      = $urandom_range(0, 99);
      if (pick < 2) begin
        r.cmd = CMD_INIT;
      end else if (pick < 40) begin
        r.cmd  = CMD_ALLOC;
        r.size = draw_size();
      end else if (pick < 75) begin
        r.cmd = CMD_FREE;
      end else begin
        r.cmd  = CMD_REALLOC;
        r.size = draw_size();
        r.has  = ($urandom_range(0, 9) != 0);
      end
      // hand back a live block most of the time
      if ((r.cmd == CMD_FREE || (r.cmd == CMD_REALLOC && r.has)) &&
          held_blocks.size() != 0 && $urandom_range(0, 9) < 8) begin
        idx = $urandom_range(0, held_blocks.size() - 1);
        b   = held_blocks[idx];
        held_blocks.delete(idx);
        r.cls     = b.cls;
        r.slot    = b.slot;
        from_held = 1'b1;
      end
      send_req(r, 1'b0, '0, from_held);
    end
  endtask

  // Result side: random stalls, two long hold-offs, field-by-field check
  initial begin
    alloc_rsp_t want;
    int seen;
    int hold;
    seen = 0;
    wait (rst_n);
    forever begin
      if (seen % 64 == 0) rcv_mode = $urandom_range(0, 2);
      hold = draw_gap(rcv_mode);
      // stall long enough for the block to fill and back-pressure requests
      if (seen == 150 || seen == 900) hold = 300;
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      seen++;
      if (pending_grants.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d class=%0d slot=%0d",
                                  status, out_class, out_slot));
      end else begin
        want = pending_grants.pop_front();
        if (status != want.status)
          report_mismatch($sformatf("status %0d, want %0d", status, want.status));
        if (out_class != want.cls)
          report_mismatch($sformatf("out_class %0d, want %0d", out_class, want.cls));
        if (out_slot != want.slot)
          report_mismatch($sformatf("out_slot %0d, want %0d", out_slot, want.slot));
        if (moved != want.moved)
          report_mismatch($sformatf("moved %0d, want %0d", moved, want.moved));
        if (free_left != want.free_left)
          report_mismatch($sformatf("free_left %0d, want %0d", free_left, want.free_left));
        if (used_now != want.used_now)
          report_mismatch($sformatf("used_now %0d, want %0d", used_now, want.used_now));
      end
    end
  end

  // Request side and run sequencing
  initial begin
    alloc_req_t r;
    cfg_arr_t   v;
    // pools as after reset
    for (int i = 0; i < REGS; i++) entries_cfg[i] = ENTRIES_RST;
    for (int i = 0; i < CLASSES; i++) rebuild_class(i, ENTRIES_RST);

    // directed rows: full pools first, then a sparse register setting
    dir_rows.push_back(row(CMD_ALLOC,       0, 0, 0,  0, 1, ST_OK,    0, 15, 0, 15, 1));
    dir_rows.push_back(row(CMD_ALLOC,       1, 0, 0,  0, 1, ST_OK,    0, 14, 0, 14, 2));
    dir_rows.push_back(row(CMD_ALLOC,     128, 0, 0,  0, 1, ST_OK,    7, 15, 0, 15, 1));
    dir_rows.push_back(row(CMD_ALLOC,     129, 1, 7, 15, 1, ST_NOFIT, 0,  0, 0,  0, 0));
    dir_rows.push_back(row(CMD_ALLOC,   65535, 1, 7, 15, 1, ST_NOFIT, 0,  0, 0,  0, 0));
    dir_rows.push_back(row(CMD_FREE,    65535, 1, 0, 15, 1, ST_OK,    0, 15, 0, 15, 1));
    dir_rows.push_back(row(CMD_FREE,        0, 0, 5,  3, 1, ST_FULL,  5,  3, 0, 16, 0));
    dir_rows.push_back(row(CMD_FREE,        0, 0, 0, 15, 1, ST_OK,    0, 15, 0, 16, 0));
    dir_rows.push_back(row(CMD_FREE,        0, 0, 0,  7, 1, ST_FULL,  0,  7, 0, 16, 0));
    dir_rows.push_back(row(CMD_REALLOC,     8, 1, 3,  2, 1, ST_OK,    3,  2, 0, 16, 0));
    dir_rows.push_back(row(CMD_REALLOC,     3, 0, 6,  9, 1, ST_OK,    2, 15, 0, 15, 1));
    dir_rows.push_back(row(CMD_REALLOC,     5, 1, 2, 15, 1, ST_OK,    3, 15, 1, 15, 1));
    dir_rows.push_back(row(CMD_REALLOC,    20, 1, 1,  4, 1, ST_FULL,  5, 15, 0, 15, 1));
    dir_rows.push_back(row(CMD_REALLOC,   200, 1, 0,  0, 1, ST_NOFIT, 0,  0, 0,  0, 0));
    dir_rows.push_back(row(CMD_REALLOC,     0, 1, 7, 15, 1, ST_OK,    7, 15, 0, 15, 1));
    dir_rows.push_back(row(CMD_INIT,    65535, 1, 7, 15, 1, ST_OK,    0,  0, 0, 16, 0));
    dir_rows.push_back(row(CMD_INIT,        0, 0, 0,  0, 1, ST_OK,    0,  0, 0,  0, 0));
    dir_rows.push_back(row(CMD_ALLOC,       1, 0, 0,  0, 1, ST_OK,    1,  0, 0,  0, 1));
    dir_rows.push_back(row(CMD_ALLOC,       1, 0, 0,  0, 1, ST_OK,    2, 15, 0, 15, 1));
    dir_rows.push_back(row(CMD_FREE,        0, 0, 0,  9, 1, ST_OK,    0,  9, 0,  1, 0));
    dir_rows.push_back(row(CMD_ALLOC,       0, 0, 0,  0, 1, ST_OK,    0,  9, 0,  0, 1));
    dir_rows.push_back(row(CMD_ALLOC,       8, 0, 0,  0, 1, ST_OK,    3, 15, 0, 15, 1));
    dir_rows.push_back(row(CMD_REALLOC,     2, 1, 1,  0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_ALLOC,     100, 0, 0,  0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_REALLOC,    65, 1, 0,  9, 0, 0, 0, 0, 0, 0, 0));

    // hold reset, then release it
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_mode = 1;
    foreach (dir_rows[i]) begin
      if (i == 16) begin
        // class 7..0: 2, 16, 8, 17, 31, 16, 1, 0
        settle_idle();
        write_entries({5'd2, 5'd16, 5'd8, 5'd17, 5'd31, 5'd16, 5'd1, 5'd0});
      end
      send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want, 1'b0);
    end

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      for (int i = 0; i < REGS; i++) begin
        case (p)
          0: v[i] = 5'd31;
          1: v[i] = 5'd0;
          3: v[i] = CFG_W'($urandom_range(1, 3));
          4: v[i] = CFG_W'($urandom_range(0, 16));
          6: v[i] = ENTRIES_RST;
          default: v[i] = CFG_W'($urandom_range(0, 31));
        endcase
      end
      settle_idle();
      write_entries(v);
      r     = '0;
      r.cmd = CMD_INIT;
      send_req(r, 1'b0, '0, 1'b0);
      run_phase(PHASE_ITEMS);
    end

    settle_idle();
    if (err_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/scpa_pkg.sv
hdl/scpa_ram.sv
hdl/scpa_counters.sv
hdl/size_class_pool_allocator_top.sv
bench/tb.sv
